FILE: rtl/core/bur_pkg.sv
// shared types and constants of the bounded uniform random unit
package bur_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned BOUND_W = 32;
	localparam int unsigned STEP_W  = $clog2(WORD_W);

	localparam logic [WORD_W-1:0] SEED_RESET = 64'h0000_0000_0000_0001;
	localparam logic [WORD_W-1:0] SEED_MIX   = 64'hdead_beef_cafe_babe;
	localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(WORD_W - 1);

	localparam int unsigned SHIFT_A = 23;
	localparam int unsigned SHIFT_B = 17;
	localparam int unsigned SHIFT_C = 26;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DRAW,
		ST_DIV,
		ST_CHECK,
		ST_DONE
	} bur_state_t;

endpackage

FILE: rtl/core/bur_mod_serial.sv
// bit-serial restoring remainder of a 64-bit word by a 32-bit divisor
module bur_mod_serial import bur_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [WORD_W-1:0]  dividend,
	input  logic [BOUND_W-1:0] divisor,
	output logic               done,
	output logic [BOUND_W-1:0] rem
);

	logic [WORD_W-1:0]  dvd_q;
	logic [BOUND_W-1:0] rem_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [BOUND_W:0]   trial;
	logic [BOUND_W:0]   diff;
	logic [BOUND_W-1:0] rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[WORD_W-1]};
		diff  = trial - {1'b0, divisor};
		if (!diff[BOUND_W]) begin
			rem_next = diff[BOUND_W-1:0];
		end else begin
			rem_next = trial[BOUND_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one dividend bit enters the partial remainder per cycle while busy
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[WORD_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/core/bounded_uniform_random_unit.sv
// top level of the bounded uniform random unit
// Returns a uniform integer below range_max from an xorshift128+ generator with
// rejection of biased draws. An item with a nonzero bound is accepted, drawn,
// reduced in the bit-serial remainder unit (one dividend bit per cycle), checked
// and handed over; each rejected draw goes back through draw, remainder and check.
// A zero bound returns 0 without drawing. Writing seed reloads the generator
// and is taken only while no item is in flight.
module bounded_uniform_random_unit import bur_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [BOUND_W-1:0] range_max,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [BOUND_W-1:0] value,
	input  logic               seed_valid,
	output logic               seed_ready,
	input  logic [WORD_W-1:0]  seed
);

	bur_state_t         state_q;
	bur_state_t         state_next;
	logic [WORD_W-1:0]  gen_a_q;
	logic [WORD_W-1:0]  gen_b_q;
	logic [BOUND_W-1:0] bound_q;
	logic [WORD_W-1:0]  sum_q;
	logic [WORD_W-1:0]  limit_q;
	logic [BOUND_W-1:0] result_q;
	logic               first_q;
	logic               out_valid_q;
	logic [BOUND_W-1:0] value_q;

	logic               in_beat;
	logic               seed_beat;
	logic               draw_en;
	logic               out_free;
	logic               reject;
	logic [WORD_W-1:0]  mix_s;
	logic [WORD_W-1:0]  sum_next;
	logic               div_r_done;
	logic               div_l_done;
	logic [BOUND_W-1:0] rem_r;
	logic [BOUND_W-1:0] rem_l;

	assign in_beat   = in_valid && in_ready;
	assign seed_beat = seed_valid && seed_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign reject    = sum_q >= limit_q;

	// xorshift128+ step
	always_comb begin
		mix_s    = gen_a_q ^ (gen_a_q << SHIFT_A);
		mix_s    = mix_s ^ (mix_s >> SHIFT_B);
		mix_s    = mix_s ^ gen_b_q ^ (gen_b_q >> SHIFT_C);
		sum_next = mix_s + gen_b_q;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					state_next = (range_max == '0) ? ST_DONE : ST_DRAW;
				end
			end
			ST_DRAW:  state_next = ST_DIV;
			ST_DIV: begin
				if (div_r_done) begin
					state_next = ST_CHECK;
				end
			end
			ST_CHECK: state_next = reject ? ST_DRAW : ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		seed_ready = 1'b0;
		draw_en    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				seed_ready = 1'b1;
			end
			ST_DRAW:  draw_en = 1'b1;
			default:  draw_en = 1'b0;
		endcase
	end

	bur_mod_serial u_mod_draw (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (draw_en),
		.dividend (sum_next),
		.divisor  (bound_q),
		.done     (div_r_done),
		.rem      (rem_r)
	);

	// remainder of all ones, needed once per item for the rejection limit
	bur_mod_serial u_mod_limit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (draw_en && first_q),
		.dividend ({WORD_W{1'b1}}),
		.divisor  (bound_q),
		.done     (div_l_done),
		.rem      (rem_l)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			gen_a_q     <= SEED_RESET;
			gen_b_q     <= SEED_RESET ^ SEED_MIX;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (seed_beat) begin
				gen_a_q <= seed;
				gen_b_q <= seed ^ SEED_MIX;
			end else if (draw_en) begin
				gen_a_q <= gen_b_q;
				gen_b_q <= mix_s;
			end
			if (in_beat) begin
				first_q <= 1'b1;
			end else if (div_l_done) begin
				first_q <= 1'b0;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			bound_q  <= range_max;
			result_q <= '0;
		end
		if (draw_en) begin
			sum_q <= sum_next;
		end
		if (div_l_done) begin
			limit_q <= ~{{(WORD_W-BOUND_W){1'b0}}, rem_l};
		end
		if (state_q == ST_CHECK && !reject) begin
			result_q <= rem_r;
		end
		if (state_q == ST_DONE && out_free) begin
			value_q <= result_q;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

endmodule

FILE: rtl/core/bur_checker.sv
// port-level checks of the bounded uniform random unit and their binding
module bur_checker import bur_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [BOUND_W-1:0] range_max,
	input logic               out_valid,
	input logic               out_ready,
	input logic [BOUND_W-1:0] value,
	input logic               seed_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value))
		else $error("result beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !seed_ready)
		else $error("new beat taken while an item is in flight");

	a_seed_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		seed_ready == in_ready)
		else $error("seed port open while an item is in flight");

	a_zero_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && range_max == '0 && !out_valid
		|=> ##1 out_valid && value == '0)
		else $error("zero bound did not give a prompt zero");

endmodule

bind bounded_uniform_random_unit bur_checker u_bur_checker (.*);

FILE: dv/bounded_uniform_random_unit_tb.sv
// self-checking testbench of the bounded uniform random unit with a generator-tracking scoreboard
`timescale 1ns / 100ps

module bounded_uniform_random_unit_tb;
	import bur_pkg::*;

	localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES = 100;

	class value_scoreboard;
		logic [WORD_W-1:0]  seed_word;
		logic [WORD_W-1:0]  word_a;
		logic [WORD_W-1:0]  word_b;
		logic [BOUND_W-1:0] expected_values[$];
		int unsigned        errors;

		function new();
			errors = 0;
			load_seed(SEED_RESET);
		endfunction

		function void load_seed(logic [WORD_W-1:0] s);
			seed_word = s;
			word_a    = s;
			word_b    = s ^ SEED_MIX;
		endfunction

		function int pending();
			return expected_values.size();
		endfunction

		function void note_bound(logic [BOUND_W-1:0] bound);
			logic [WORD_W-1:0] wide;
			logic [WORD_W-1:0] limit;
			logic [WORD_W-1:0] s;
			logic [WORD_W-1:0] t;
			logic [WORD_W-1:0] r;
			if (bound == '0) begin
				expected_values.push_back('0);
				return;
			end
			wide  = {{(WORD_W-BOUND_W){1'b0}}, bound};
			limit = ALL_ONES - (ALL_ONES % wide);
			do begin
				s      = word_a;
				t      = word_b;
				word_a = t;
				s      = s ^ (s << SHIFT_A);
				s      = s ^ (s >> SHIFT_B);
				s      = s ^ t ^ (t >> SHIFT_C);
				word_b = s;
				r      = s + t;
			end while (r >= limit);
			expected_values.push_back(BOUND_W'(r % wide));
		endfunction

		function void check_value(logic [BOUND_W-1:0] actual);
			logic [BOUND_W-1:0] want;
			if (expected_values.size() == 0) begin
				$display("%0t: value beat with no request waiting, expected none actual %0d",
					$time, actual);
				errors++;
				return;
			end
			want = expected_values.pop_front();
			if (want !== actual) begin
				$display("%0t: value mismatch, expected %0d actual %0d", $time, want, actual);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [BOUND_W-1:0] range_max;
	logic               out_valid;
	logic               out_ready;
	logic [BOUND_W-1:0] value;
	logic               seed_valid;
	logic               seed_ready;
	logic [WORD_W-1:0]  seed;

	value_scoreboard sb = new();
	bit              tx_idle_en;
	bit              rx_idle_en;
	bit              hold_req;
	int unsigned     quiet_cycles;

	bounded_uniform_random_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.range_max  (range_max),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.seed_valid (seed_valid),
		.seed_ready (seed_ready),
		.seed       (seed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_bound(input logic [BOUND_W-1:0] bound);
		int gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		range_max <= bound;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		logic [BOUND_W-1:0] b;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0: b = '0;
				1: b = 32'd1;
				2: b = 32'($urandom_range(2, 16));
				3: b = 32'($urandom_range(17, 100000));
				4: b = 32'hffff_ffff - 32'($urandom_range(0, 15));
				5: b = 32'd1 << $urandom_range(0, 31);
				default: b = $urandom();
			endcase
			send_bound(b);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_seed(input logic [WORD_W-1:0] word);
		seed_valid <= 1'b1;
		seed       <= word;
		do @(posedge clk); while (!seed_ready);
		@(negedge clk);
		seed_valid <= 1'b0;
	endtask

	// receiver side: random stalls, plus one long hold-off on request
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 18);
				out_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (seed_valid && seed_ready)
				sb.load_seed(seed);
			if (out_valid && out_ready)
				sb.check_value(value);
			if (in_valid && in_ready)
				sb.note_bound(range_max);
			if ((seed_valid && seed_ready) || (out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		logic [BOUND_W-1:0] directed_bounds [20];
		logic [WORD_W-1:0]  colv [WORD_W];
		logic [WORD_W:0]    rows [WORD_W];
		int                 pivots [WORD_W];
		logic [WORD_W:0]    tmp;
		logic [WORD_W-1:0]  v;
		logic [WORD_W-1:0]  target;
		logic [WORD_W-1:0]  reject_seed;
		int                 rank;
		int                 p;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		range_max    = '0;
		seed_valid   = 1'b0;
		seed         = '0;
		tx_idle_en   = 1'b1;
		rx_idle_en   = 1'b1;
		hold_req     = 1'b0;
		quiet_cycles = 0;

		// seed whose first draw is all ones, so every nonzero bound rejects it
		target = ALL_ONES ^ (SEED_MIX >> SHIFT_C);
		for (int i = 0; i < WORD_W; i++) begin
			v = 64'd1 << i;
			v = v ^ (v << SHIFT_A);
			v = v ^ (v >> SHIFT_B);
			colv[i] = v ^ ((64'd1 << i) >> SHIFT_C);
		end
		for (int j = 0; j < WORD_W; j++) begin
			for (int i = 0; i < WORD_W; i++)
				rows[j][i] = colv[i][j];
			rows[j][WORD_W] = target[j];
		end
		rank = 0;
		for (int c = 0; c < WORD_W; c++) begin
			p = -1;
			for (int r = rank; r < WORD_W; r++)
				if (p < 0 && rows[r][c])
					p = r;
			if (p >= 0) begin
				tmp = rows[p];
				rows[p] = rows[rank];
				rows[rank] = tmp;
				for (int r = 0; r < WORD_W; r++)
					if (r != rank && rows[r][c])
						rows[r] = rows[r] ^ rows[rank];
				pivots[rank] = c;
				rank++;
			end
		end
		reject_seed = '0;
		for (int k = 0; k < rank; k++)
			reject_seed[pivots[k]] = rows[k][WORD_W];

		directed_bounds = '{
			32'd0, 32'd1, 32'd2, 32'd3, 32'hffff_ffff, 32'hffff_fffe, 32'h8000_0000,
			32'h8000_0001, 32'h7fff_ffff, 32'd0, 32'd0, 32'd5, 32'd10, 32'd1000,
			32'h1234_5678, 32'haaaa_aaaa, 32'h5555_5555, 32'd1, 32'd64, 32'd0
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// generator straight out of reset
		foreach (directed_bounds[i])
			send_bound(directed_bounds[i]);
		drain();

		// rejected first draw
		write_seed(reject_seed);
		send_bound(32'd1);
		send_bound(32'd7);
		drain();
		write_seed(reject_seed);
		send_bound(32'hffff_ffff);
		send_bound(32'd3);
		drain();

		write_seed('0);
		send_random(100);
		drain();

		// long receiver hold-off while requests keep coming
		write_seed(ALL_ONES);
		hold_req = 1'b1;
		send_random(120);
		drain();

		write_seed(SEED_MIX);
		tx_idle_en = 1'b0;
		send_random(50);
		tx_idle_en = 1'b1;
		send_random(50);
		drain();

		// sender pause until everything is back
		write_seed({$urandom(), $urandom()});
		send_random(75);
		drain();
		send_random(75);
		drain();

		write_seed({$urandom(), $urandom()});
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_random(130);
		drain();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
